FILE: rtl/core/ppk_pkg.sv
`default_nettype none

package ppk_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic [47:0]        stamp_t;
  typedef logic [15:0]        pkpk_t;

  localparam sample_t SampleMax = 16'sh7FFF;
  localparam sample_t SampleMin = 16'sh8000;

  // One accepted input item.
  typedef struct packed {
    sample_t sample;
    stamp_t  sample_time;
  } item_t;

  // One measurement result.
  typedef struct packed {
    stamp_t result_time;
    pkpk_t  pk_pk_value;
    stamp_t previous_duration;
    logic   previous_duration_valid;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/ppk_in_stage.sv
`default_nettype none

module ppk_in_stage (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  ppk_pkg::item_t  in_item,
  input  wire             advance,
  output logic            step,
  output ppk_pkg::item_t  item
);
  import ppk_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;
  assign step     = valid_r && advance;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppk_tracker.sv
`default_nettype none

module ppk_tracker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               step,
  input  ppk_pkg::item_t    item,
  input  ppk_pkg::sample_t  midpoint,
  output logic              res_valid,
  output ppk_pkg::result_t  res
);
  import ppk_pkg::*;

  sample_t running_min_r, running_min_nxt;
  stamp_t  min_time_r, min_time_nxt;
  sample_t running_max_r, running_max_nxt;
  sample_t held_max_r, held_max_nxt;
  logic    held_max_valid_r, held_max_valid_nxt;
  logic    was_low_r, was_low_nxt;
  logic    first_pending_r, first_pending_nxt;
  stamp_t  last_result_time_r, last_result_time_nxt;
  logic    have_result_r, have_result_nxt;

  logic              high;
  logic signed [16:0] diff;

  assign high = item.sample > midpoint;
  assign diff = {held_max_r[15], held_max_r} - {running_min_r[15], running_min_r};

  always_comb begin
    running_min_nxt      = running_min_r;
    min_time_nxt         = min_time_r;
    running_max_nxt      = running_max_r;
    held_max_nxt         = held_max_r;
    held_max_valid_nxt   = held_max_valid_r;
    was_low_nxt          = was_low_r;
    first_pending_nxt    = first_pending_r;
    last_result_time_nxt = last_result_time_r;
    have_result_nxt      = have_result_r;
    res_valid            = 1'b0;

    res.result_time             = min_time_r;
    res.pk_pk_value             = diff[16] ? '0 : diff[15:0];
    res.previous_duration       = have_result_r ? (min_time_r - last_result_time_r) : '0;
    res.previous_duration_valid = have_result_r;

    if (high) begin
      was_low_nxt = 1'b0;
      // A zero timestamp stands for "no minimum seen in this low phase".
      if ((min_time_r != '0) && held_max_valid_r) begin
        if (first_pending_r) begin
          first_pending_nxt = 1'b0;
        end else begin
          res_valid            = step;
          last_result_time_nxt = min_time_r;
          have_result_nxt      = 1'b1;
        end
      end
      min_time_nxt    = '0;
      running_min_nxt = SampleMax;
      if (item.sample > running_max_r) begin
        running_max_nxt = item.sample;
      end
    end else begin
      if (!was_low_r) begin
        held_max_nxt       = running_max_r;
        held_max_valid_nxt = 1'b1;
        running_max_nxt    = SampleMin;
        was_low_nxt        = 1'b1;
      end
      if (item.sample < running_min_r) begin
        running_min_nxt = item.sample;
        min_time_nxt    = item.sample_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_min_r      <= SampleMax;
      min_time_r         <= '0;
      running_max_r      <= SampleMin;
      held_max_r         <= '0;
      held_max_valid_r   <= 1'b0;
      was_low_r          <= 1'b1;
      first_pending_r    <= 1'b1;
      last_result_time_r <= '0;
      have_result_r      <= 1'b0;
    end else if (step) begin
      running_min_r      <= running_min_nxt;
      min_time_r         <= min_time_nxt;
      running_max_r      <= running_max_nxt;
      held_max_r         <= held_max_nxt;
      held_max_valid_r   <= held_max_valid_nxt;
      was_low_r          <= was_low_nxt;
      first_pending_r    <= first_pending_nxt;
      last_result_time_r <= last_result_time_nxt;
      have_result_r      <= have_result_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppk_out_stage.sv
`default_nettype none

module ppk_out_stage (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               load,
  input  ppk_pkg::result_t  res,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              slot_free,
  output ppk_pkg::result_t  out_res
);
  import ppk_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_valid = valid_r;
  assign out_res   = res_r;
  // The slot can take a new result if it is empty or being drained now.
  assign slot_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/per_cycle_peak_to_peak.sv
// Per-cycle peak-to-peak measurement. Each input item is one signed 16-bit
// sample with a 48-bit timestamp. Samples strictly above the programmed
// midpoint belong to the high half of the waveform, where the running maximum
// is tracked; samples at or below it belong to the low half, where the running
// minimum and its timestamp are tracked. On re-entry into the high half a
// completed cycle yields one result item: the held maximum minus the minimum
// (floored at zero), stamped with the minimum's time, plus the distance to the
// previous result's stamp. The first completed cycle after reset yields no
// item, and a minimum recorded at timestamp zero counts as no minimum at all.
// Throughput is one item per clock while no result is stalled. An item is
// held in the input register and is folded into the tracking state as it
// leaves it, at the same edge at which its result, if any, is loaded into the
// output register. The single output register decouples the two sides:
// while a result waits under out_stall the input register can still take one
// item, and in_stall rises only when both registers are full and the result
// is stalled. The midpoint is written through cfg_wr_en / cfg_wr_data and must
// only change while the block is idle. Reset is synchronous and active low.
`default_nettype none

module per_cycle_peak_to_peak (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr_en,
  input  ppk_pkg::sample_t   cfg_wr_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  ppk_pkg::sample_t   in_sample,
  input  ppk_pkg::stamp_t    in_sample_time,
  output logic               out_valid,
  input  wire                out_stall,
  output ppk_pkg::stamp_t    out_result_time,
  output ppk_pkg::pkpk_t     out_pk_pk_value,
  output ppk_pkg::stamp_t    out_previous_duration,
  output logic               out_previous_duration_valid
);
  import ppk_pkg::*;

  sample_t midpoint_r;
  item_t   in_item;
  item_t   item;
  logic    step;
  logic    slot_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      midpoint_r <= '0;
    end else if (cfg_wr_en) begin
      midpoint_r <= cfg_wr_data;
    end
  end

  assign in_item.sample      = in_sample;
  assign in_item.sample_time = in_sample_time;

  ppk_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (slot_free),
    .step     (step),
    .item     (item)
  );

  ppk_tracker u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .midpoint  (midpoint_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ppk_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot_free (slot_free),
    .out_res   (out_res)
  );

  assign out_result_time             = out_res.result_time;
  assign out_pk_pk_value             = out_res.pk_pk_value;
  assign out_previous_duration       = out_res.previous_duration;
  assign out_previous_duration_valid = out_res.previous_duration_valid;

endmodule

`default_nettype wire

FILE: rtl/core/ppk_checker.sv
`default_nettype none

module ppk_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input ppk_pkg::stamp_t    out_previous_duration,
  input wire                out_previous_duration_valid
);

  // A result waiting under stall stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // The input only backs up when the result register is full and stalled.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Without an earlier result the duration field reads zero.
  a_dur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_previous_duration_valid |-> out_previous_duration == '0)
    else $error("duration nonzero without previous result");

  // Once a result has gone out, every later result has a previous one.
  a_prev_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid || out_previous_duration_valid)
    else $error("previous_duration_valid cleared after a result");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind per_cycle_peak_to_peak ppk_checker u_ppk_checker (.*);

`default_nettype wire

FILE: test/per_cycle_peak_to_peak_tb.sv
`timescale 1ns / 1ps

module per_cycle_peak_to_peak_tb;
  import ppk_pkg::*;

  // Scoreboard: it tracks the waveform the same way the block should and keeps
  // the peak-to-peak results that are still owed by the block, oldest first.
  class peak_scoreboard;
    sample_t midpoint;
    sample_t low_min;
    stamp_t  low_min_stamp;
    sample_t high_max;
    sample_t held_max;
    bit      held_valid;
    bit      in_low;
    bit      drop_first;
    stamp_t  prev_stamp;
    bit      have_prev;
    result_t owed_q[$];
    int      errors;

    function new();
      errors = 0;
      midpoint = '0;
      low_min = SampleMax;
      low_min_stamp = '0;
      high_max = SampleMin;
      held_max = '0;
      held_valid = 1'b0;
      in_low = 1'b1;
      drop_first = 1'b1;
      prev_stamp = '0;
      have_prev = 1'b0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Folds one accepted item into the tracking state.
    function void note_item(sample_t s, stamp_t t);
      int      d;
      result_t r;
      if (s > midpoint) begin
        in_low = 1'b0;
        if (low_min_stamp != '0 && held_valid) begin
          if (drop_first) begin
            drop_first = 1'b0;
          end else begin
            d = int'(held_max) - int'(low_min);
            if (d < 0) d = 0;
            if (d > 65535) d = 65535;
            r.result_time = low_min_stamp;
            r.pk_pk_value = d[15:0];
            r.previous_duration = have_prev ? low_min_stamp - prev_stamp : '0;
            r.previous_duration_valid = have_prev;
            prev_stamp = low_min_stamp;
            have_prev = 1'b1;
            owed_q = {owed_q, r};
          end
        end
        low_min_stamp = '0;
        low_min = SampleMax;
        if (s > high_max) high_max = s;
      end else begin
        if (!in_low) begin
          held_max = high_max;
          held_valid = 1'b1;
          high_max = SampleMin;
          in_low = 1'b1;
        end
        if (s < low_min) begin
          low_min = s;
          low_min_stamp = t;
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: result_time %0d, pk_pk_value %0d",
               got.result_time, got.pk_pk_value);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.result_time !== want.result_time) begin
        $error("result_time: expected %0d, got %0d", want.result_time, got.result_time);
        errors++;
      end
      if (got.pk_pk_value !== want.pk_pk_value) begin
        $error("pk_pk_value: expected %0d, got %0d", want.pk_pk_value, got.pk_pk_value);
        errors++;
      end
      if (got.previous_duration !== want.previous_duration) begin
        $error("previous_duration: expected %0d, got %0d",
               want.previous_duration, got.previous_duration);
        errors++;
      end
      if (got.previous_duration_valid !== want.previous_duration_valid) begin
        $error("previous_duration_valid: expected %0d, got %0d",
               want.previous_duration_valid, got.previous_duration_valid);
        errors++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    cfg_wr_en;
  sample_t cfg_wr_data;
  logic    in_valid;
  logic    in_stall;
  sample_t in_sample;
  stamp_t  in_sample_time;
  logic    out_valid;
  logic    out_stall;
  stamp_t  out_result_time;
  pkpk_t   out_pk_pk_value;
  stamp_t  out_previous_duration;
  logic    out_previous_duration_valid;

  peak_scoreboard sb;
  // While calm is set neither side idles, so the block runs at full rate.
  bit     calm;
  // Running timestamp of the synthetic waveform.
  stamp_t wave_stamp;

  per_cycle_peak_to_peak uut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_wr_en                  (cfg_wr_en),
    .cfg_wr_data                (cfg_wr_data),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_sample                  (in_sample),
    .in_sample_time             (in_sample_time),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_result_time            (out_result_time),
    .out_pk_pk_value            (out_pk_pk_value),
    .out_previous_duration      (out_previous_duration),
    .out_previous_duration_valid(out_previous_duration_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is bounded by a fixed time far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The receiver stalls at random, 13 percent of the time, except while calm.
  // The stall changes at the falling edge so it is stable at the rising edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  // A result item is taken at a rising edge with out_valid high and no stall.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result('{result_time: out_result_time,
                        pk_pk_value: out_pk_pk_value,
                        previous_duration: out_previous_duration,
                        previous_duration_valid: out_previous_duration_valid});
    end
  end

  // Presents one item and holds it until the block takes it. Random idle
  // cycles go in front of the item; valid is not dropped between two items
  // that follow each other without a gap.
  task automatic send_item(sample_t s, stamp_t t);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_sample_time <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(s, t);
  endtask

  // Stops sending and waits for every owed result. An item that causes no
  // result may still sit in the block's two-stage path, so the task also lets
  // that path drain before the block counts as idle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Changes the midpoint; only done with the block idle.
  task automatic retune(int mid);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sample_t'(mid);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.midpoint = sample_t'(mid);
  endtask

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // A value within [lo, hi], with the two ends of the band favored.
  function automatic sample_t in_band(int lo, int hi);
    int r;
    r = $urandom_range(9);
    if (r == 0) return sample_t'(lo);
    if (r == 1) return sample_t'(hi);
    return sample_t'(pick(lo, hi));
  endfunction

  // Timestamps mostly climb in small steps. Now and then a stamp is zero,
  // which the block treats as no minimum, or jumps anywhere in the 48-bit
  // range, which also makes time run backwards and wrap.
  function automatic stamp_t next_stamp();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 5) wave_stamp = stamp_t'({$urandom, $urandom});
    else wave_stamp = wave_stamp + stamp_t'($urandom_range(1000, 1));
    return wave_stamp;
  endfunction

  // Random waveform around the current midpoint: alternating high and low runs
  // of a few samples each, so that cycles complete often. A small share of
  // items is plain noise that may fall on either side.
  task automatic run_phase(int count);
    int n;
    int len;
    int mid;
    int k;
    n = 0;
    mid = int'(sb.midpoint);
    while (n < count) begin
      if ($urandom_range(99) < 8) begin
        send_item(sample_t'($urandom), next_stamp());
        n++;
      end else begin
        if (mid < 32767) begin
          len = $urandom_range(6, 1);
          for (k = 0; k < len; k++) send_item(in_band(mid + 1, 32767), next_stamp());
          n += len;
        end
        len = $urandom_range(6, 1);
        for (k = 0; k < len; k++) send_item(in_band(-32768, mid), next_stamp());
        n += len;
      end
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    wave_stamp = '0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_sample = '0;
    in_sample_time = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset midpoint of zero. The first completed
    // cycle is dropped; the second spans the full sample range.
    send_item(16'sd100, 48'd10);
    send_item(SampleMin, 48'd20);
    send_item(SampleMax, 48'd30);
    send_item(16'sd0, 48'd40);
    send_item(SampleMin, 48'd50);
    send_item(16'sd1, 48'd60);
    // A minimum stamped at time zero counts as none, so no result here.
    send_item(-16'sd100, 48'd0);
    send_item(16'sd5, 48'd70);
    // A minimum at the latest possible stamp, then one far earlier, so the
    // duration between results wraps around.
    send_item(-16'sd7, 48'hFFFF_FFFF_FFFF);
    send_item(16'sd200, 48'd80);
    send_item(-16'sd3, 48'd5);
    send_item(16'sd50, 48'd90);

    // With the midpoint at the top code, a low sample of 32767 never becomes
    // the minimum because the compare against the reset minimum is strict.
    retune(32767);
    send_item(SampleMax, 48'd110);
    send_item(SampleMax, 48'd120);

    // With the midpoint at the bottom, only the lowest code is low.
    retune(-32768);
    send_item(-16'sd32767, 48'd130);
    send_item(SampleMin, 48'd140);
    send_item(16'sd0, 48'd150);
    send_item(16'sd300, 48'd160);

    // Raising the midpoint above the held maximum leaves a minimum above it,
    // so the difference would be negative and comes out as zero.
    retune(1000);
    send_item(16'sd500, 48'd170);
    send_item(16'sd1500, 48'd180);

    // Random part, one phase per midpoint setting. In the first phase the
    // sender also pauses halfway until every owed result has arrived.
    retune(0);
    run_phase(110);
    settle();
    run_phase(110);
    retune(pick(-32768, 32767));
    run_phase(220);
    // A phase at full rate on both sides.
    retune(pick(-2000, 2000));
    calm = 1'b1;
    run_phase(220);
    calm = 1'b0;
    retune(-32768);
    run_phase(220);
    // Nothing is ever high here, so this phase stays short.
    retune(32767);
    run_phase(40);
    retune(pick(-32768, 32767));
    run_phase(220);
    retune(pick(-500, 500));
    run_phase(220);

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
